@@ design/bch_generator_polynomial_top_defines.svh @@
// Assertion macros for the BCH generator polynomial block
`ifndef BCH_GENERATOR_POLYNOMIAL_TOP_DEFINES_SVH
`define BCH_GENERATOR_POLYNOMIAL_TOP_DEFINES_SVH
`define BCHG_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCHG_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/bchg_pkg.sv @@
// Shared types and constants of the BCH generator polynomial block
package bchg_pkg;
  localparam int GF_W = 6;
  localparam int POLY_W = 64;
  localparam logic [1:0] REG_FIELD_DEGREE = 2'd0;
  localparam logic [1:0] REG_PRIM_POLY = 2'd1;
  typedef logic [GF_W-1:0] gf_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_POW   = 8'b00000010,
    ST_ROOT  = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_MULT  = 8'b00010000,
    ST_PACK  = 8'b00100000,
    ST_DONE  = 8'b01000000,
    ST_FLAG  = 8'b10000000
  } state_t;

  typedef struct packed {
    logic start;
    gf_t  a;
    gf_t  b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    gf_t  p;
  } mul_rsp_t;
endpackage

@@ design/bchg_gf_mul.sv @@
// Bit-serial GF(2^m) multiplier, one bit of the multiplier per cycle
module bchg_gf_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          m,
  input  bchg_pkg::gf_t       tail,
  input  bchg_pkg::mul_req_t  req,
  output bchg_pkg::mul_rsp_t  rsp
);
  bchg_pkg::gf_t a;
  bchg_pkg::gf_t b;
  bchg_pkg::gf_t acc;
  logic [2:0] cnt;
  logic busy;
  logic [bchg_pkg::GF_W:0] a_sh;
  bchg_pkg::gf_t a_next;
  bchg_pkg::gf_t mask;

  always_comb begin
    mask = bchg_pkg::gf_t'((7'd1 << m) - 7'd1);
    a_sh = {a, 1'b0};
    if (a_sh[m])
      a_next = (a_sh[bchg_pkg::GF_W-1:0] & mask) ^ tail;
    else
      a_next = a_sh[bchg_pkg::GF_W-1:0] & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        a <= req.a;
        b <= req.b;
        acc <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (b[0])
          acc <= acc ^ a;
        a <= a_next;
        b <= b >> 1;
        cnt <= cnt + 3'd1;
        if (cnt == m - 3'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.p <= (b[0] ? acc ^ a : acc) & mask;
        end
      end
    end
  end
endmodule

@@ design/bchg_core.sv @@
// Sequencer: power table, coset marking and serial root products
module bchg_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [5:0]   distance,
  input  logic [2:0]   m,
  input  logic [6:0]   prim_poly,
  output logic         busy,
  output logic         done,
  output logic [63:0]  gen_poly,
  output logic [5:0]   gen_degree,
  output logic [5:0]   code_dimension,
  output logic         not_primitive
);
  bchg_pkg::state_t state;
  bchg_pkg::gf_t pw [0:63];
  logic [63:0] roots;
  bchg_pkg::gf_t cf [0:bchg_pkg::POLY_W-1];
  bchg_pkg::gf_t n1;
  bchg_pkg::gf_t tail;
  bchg_pkg::gf_t t;
  bchg_pkg::gf_t i;
  bchg_pkg::gf_t i_dec;
  bchg_pkg::gf_t j;
  bchg_pkg::gf_t e;
  bchg_pkg::gf_t d;
  bchg_pkg::gf_t deg;
  bchg_pkg::gf_t root;
  bchg_pkg::gf_t rd_hi;
  bchg_pkg::gf_t rd_lo;
  logic prim;
  logic [1:0] ph;
  logic [63:0] g;
  bchg_pkg::mul_req_t req;
  bchg_pkg::mul_rsp_t rsp;
  bchg_pkg::gf_t e2;
  bchg_pkg::gf_t t_next;
  logic [bchg_pkg::GF_W:0] t_sh;

  always_comb begin
    t_sh = {t, 1'b0};
    if (t_sh[m])
      t_next = (t_sh[bchg_pkg::GF_W-1:0] & n1) ^ tail;
    else
      t_next = t_sh[bchg_pkg::GF_W-1:0] & n1;
    e2 = ({e, 1'b0} >= {1'b0, n1}) ? bchg_pkg::gf_t'({e, 1'b0} - {1'b0, n1})
                                   : bchg_pkg::gf_t'({e, 1'b0});
  end

  bchg_gf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .m    (m),
    .tail (tail),
    .req  (req),
    .rsp  (rsp)
  );

  assign busy = (state != bchg_pkg::ST_IDLE);
  assign i_dec = i - 6'd1;

  always_ff @(posedge clk) begin
    rd_hi <= cf[i];
    rd_lo <= cf[i_dec];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bchg_pkg::ST_IDLE;
      done <= 1'b0;
      req.start <= 1'b0;
      ph <= 2'd0;
    end else begin
      done <= 1'b0;
      req.start <= 1'b0;
      case (state)
        bchg_pkg::ST_IDLE: begin
          if (start) begin
            n1 <= bchg_pkg::gf_t'((7'd1 << m) - 7'd1);
            tail <= prim_poly[5:0] & bchg_pkg::gf_t'((7'd1 << m) - 7'd1);
            d <= distance;
            t <= 6'd1;
            i <= '0;
            prim <= 1'b1;
            state <= bchg_pkg::ST_POW;
          end
        end
        bchg_pkg::ST_POW: begin
          pw[i] <= t;
          t <= t_next;
          i <= i + 6'd1;
          if (t_next == 6'd1 && i + 6'd1 < n1)
            prim <= 1'b0;
          if (i + 6'd1 == n1) begin
            if (t_next != 6'd1 || !prim || (t_next == 6'd1 && i + 6'd1 < n1))
              state <= bchg_pkg::ST_FLAG;
            else begin
              if (d > n1)
                d <= n1;
              roots <= '0;
              j <= 6'd1;
              e <= 6'd1;
              state <= bchg_pkg::ST_ROOT;
            end
          end
        end
        bchg_pkg::ST_ROOT: begin
          if (j >= d) begin
            cf[0] <= 6'd1;
            deg <= '0;
            e <= 6'd1;
            state <= bchg_pkg::ST_SCAN;
          end else begin
            roots[e] <= 1'b1;
            if (e2 == j) begin
              j <= j + 6'd1;
              e <= j + 6'd1;
            end else
              e <= e2;
          end
        end
        bchg_pkg::ST_SCAN: begin
          if (e >= n1) begin
            g <= '0;
            i <= '0;
            ph <= 2'd0;
            state <= bchg_pkg::ST_PACK;
          end else if (roots[e]) begin
            root <= pw[e];
            i <= deg + 6'd1;
            ph <= 2'd0;
            state <= bchg_pkg::ST_MULT;
          end else
            e <= e + 6'd1;
        end
        bchg_pkg::ST_MULT: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (ph == 2'd1) begin
            req.start <= 1'b1;
            req.a <= (i == deg + 6'd1) ? '0 : rd_hi;
            req.b <= root;
            ph <= 2'd2;
          end else if (rsp.done) begin
            ph <= 2'd0;
            if (i == '0) begin
              cf[0] <= rsp.p;
              deg <= deg + 6'd1;
              e <= e + 6'd1;
              state <= bchg_pkg::ST_SCAN;
            end else begin
              cf[i] <= rsp.p ^ rd_lo;
              i <= i - 6'd1;
            end
          end
        end
        bchg_pkg::ST_PACK: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            g[i] <= (rd_hi != '0);
            ph <= 2'd0;
            if (i == deg) begin
              state <= bchg_pkg::ST_DONE;
            end else
              i <= i + 6'd1;
          end
        end
        bchg_pkg::ST_DONE: begin
          gen_poly <= g;
          gen_degree <= deg;
          code_dimension <= n1 - deg;
          not_primitive <= 1'b0;
          done <= 1'b1;
          state <= bchg_pkg::ST_IDLE;
        end
        bchg_pkg::ST_FLAG: begin
          gen_poly <= 64'd1;
          gen_degree <= '0;
          code_dimension <= n1;
          not_primitive <= 1'b1;
          done <= 1'b1;
          state <= bchg_pkg::ST_IDLE;
        end
        default: state <= bchg_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/bch_generator_polynomial_top.sv @@
// Top level of the BCH generator polynomial block
// Steps: 2^m-1 power steps, coset marking, then coefficient updates in the
// bit-serial GF multiplier; the work is largest for m = 6 and distance 63,
// set by the quadratic number of updates.
// One item at a time; busy high from the transfer until done.
// Result strobe lasts one cycle and cannot be stalled.
// Synchronous reset restores field_degree 6 and prim_poly 67.
module bch_generator_polynomial_top #(
  parameter int MAX_FIELD_DEGREE = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  designed_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [63:0] gen_poly,
  output logic [5:0]  gen_degree,
  output logic [5:0]  code_dimension,
  output logic        not_primitive
);
  logic [2:0] field_degree;
  logic [6:0] prim_poly;
  logic [2:0] m_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= 3'd6;
      prim_poly <= 7'd67;
    end else if (cfg_valid) begin
      case (cfg_index)
        bchg_pkg::REG_FIELD_DEGREE: field_degree <= cfg_data[2:0];
        bchg_pkg::REG_PRIM_POLY: prim_poly <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (field_degree < 3'd2)
      m_eff = 3'd2;
    else if (field_degree > 3'(MAX_FIELD_DEGREE))
      m_eff = 3'(MAX_FIELD_DEGREE);
    else
      m_eff = field_degree;
  end

  bchg_core u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .distance       (designed_distance),
    .m              (m_eff),
    .prim_poly      (prim_poly),
    .busy           (busy),
    .done           (done),
    .gen_poly       (gen_poly),
    .gen_degree     (gen_degree),
    .code_dimension (code_dimension),
    .not_primitive  (not_primitive)
  );
endmodule

@@ design/bchg_checker.sv @@
// Port-level checker for the BCH generator polynomial block
`include "bch_generator_polynomial_top_defines.svh"
module bchg_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] gen_poly
);
  `BCHG_ASSERT_IMPL(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  `BCHG_ASSERT_IMPL(a_done_idle, clk, rst, done |-> !busy, "done while busy")
  `BCHG_ASSERT_IMPL(a_done_fell, clk, rst, done |-> $past(busy), "done without work")
  `BCHG_ASSERT_IMPL(a_g_odd, clk, rst, done |-> gen_poly[0], "constant term zero")
  `BCHG_ASSERT_NORST(a_rst_idle, clk, $past(rst) |-> !busy, "busy after reset")
endmodule

bind bch_generator_polynomial_top bchg_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .gen_poly(gen_poly)
);

@@ sim/tb_bch_generator_polynomial_top.sv @@
// Self-checking testbench of the BCH generator polynomial block
module tb_bch_generator_polynomial_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] poly;
    logic [5:0]  deg;
    logic [5:0]  dim;
    logic        flag;
  } bch_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  designed_distance = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [63:0] gen_poly;
  logic [5:0]  gen_degree;
  logic [5:0]  code_dimension;
  logic        not_primitive;

  bch_generator_polynomial_top u_top (.*);

  always #1 clk = ~clk;

  logic [2:0] cur_m = 3'd6;
  logic [6:0] cur_poly = 7'd67;
  logic [5:0] dist_q[$];
  bch_res_t   gen_q[$];
  int         mismatches = 0;
  int         sent = 0;
  int         got = 0;
  int         prim_seen = 0;
  int         nonprim_seen = 0;
  int         cycles = 0;
  bit         drv_en = 1'b0;
  int         gap = 0;
  logic [2:0] ms[8] = '{3'd6, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd7, 3'd1};
  logic [6:0] ps[8] = '{7'd67, 7'd7, 7'd11, 7'd19, 7'd37, 7'd127, 7'd0, 7'd13};

  function automatic void enq_dist(logic [5:0] v);
    dist_q.insert(dist_q.size(), v);
  endfunction

  function automatic void enq_exp(bch_res_t v);
    gen_q.insert(gen_q.size(), v);
  endfunction

  function automatic logic [5:0] gf_mult(logic [5:0] a, logic [5:0] b, int m,
                                         logic [5:0] tl);
    logic [6:0] aa;
    logic [5:0] acc;
    logic [5:0] msk;
    msk = 6'((7'd1 << m) - 1);
    aa = {1'b0, a};
    acc = '0;
    for (int i = 0; i < m; i++) begin
      if (b[i]) acc ^= aa[5:0];
      aa = aa << 1;
      if (aa[m]) aa = {1'b0, aa[5:0] & msk} ^ {1'b0, tl};
    end
    return acc & msk;
  endfunction

  function automatic bch_res_t bch_generator(logic [5:0] delta, logic [2:0] mr,
                                             logic [6:0] pr);
    bch_res_t   r;
    int         m;
    int         n1;
    int         d;
    int         e;
    int         deg;
    logic [5:0] tl;
    logic [5:0] t;
    logic [5:0] pw[64];
    logic [5:0] cf[65];
    logic [63:0] roots;
    bit         prim;
    m = (mr < 2) ? 2 : (mr > 6) ? 6 : mr;
    n1 = (1 << m) - 1;
    tl = 6'(pr & n1);
    prim = 1'b1;
    t = 6'd1;
    for (int i = 0; i < n1; i++) begin
      pw[i] = t;
      t = gf_mult(t, 6'd2, m, tl);
      if (t == 6'd1 && i + 1 < n1) prim = 1'b0;
    end
    if (t != 6'd1) prim = 1'b0;
    if (!prim) begin
      r.poly = 64'd1; r.deg = '0; r.dim = 6'(n1); r.flag = 1'b1;
      return r;
    end
    d = (delta > n1) ? n1 : delta;
    roots = '0;
    for (int j = 1; j < d; j++) begin
      e = j;
      do begin
        roots[e] = 1'b1;
        e = (2 * e) % n1;
      end while (e != j);
    end
    for (int i = 0; i < 65; i++) cf[i] = '0;
    cf[0] = 6'd1;
    deg = 0;
    for (int k = 1; k < n1; k++) begin
      if (roots[k]) begin
        for (int i = deg + 1; i > 0; i--) cf[i] = gf_mult(cf[i], pw[k], m, tl) ^ cf[i-1];
        cf[0] = gf_mult(cf[0], pw[k], m, tl);
        deg++;
      end
    end
    r.poly = '0;
    for (int i = 0; i <= deg && i < 64; i++) if (cf[i] != 0) r.poly[i] = 1'b1;
    r.deg = 6'(deg); r.dim = 6'(n1 - deg); r.flag = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      enq_exp(bch_generator(designed_distance, cur_m, cur_poly));
      sent <= sent + 1;
      start <= 1'b0;
      gap <= $urandom_range(0, 16);
    end else if (!start && drv_en && dist_q.size() > 0) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else begin
        designed_distance <= dist_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      bch_res_t ex;
      got <= got + 1;
      if (gen_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result poly %h", gen_poly);
      end else begin
        ex = gen_q.pop_front();
        if (ex.flag) nonprim_seen <= nonprim_seen + 1;
        else prim_seen <= prim_seen + 1;
        if (ex.poly !== gen_poly || ex.deg !== gen_degree || ex.dim !== code_dimension ||
            ex.flag !== not_primitive) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp %h/%0d/%0d/%b got %h/%0d/%0d/%b", ex.poly, ex.deg,
                     ex.dim, ex.flag, gen_poly, gen_degree, code_dimension, not_primitive);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 50000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drain();
    do begin
      @(negedge clk);
    end while (dist_q.size() > 0 || start || busy || gen_q.size() > 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [6:0] val);
    drv_en = 1'b0;
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bchg_pkg::REG_FIELD_DEGREE) cur_m = val[2:0];
    else if (idx == bchg_pkg::REG_PRIM_POLY) cur_poly = val;
  endtask

  task automatic feed(int n, bit wide);
    for (int i = 0; i < n; i++)
      enq_dist(wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 16)));
    drv_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (ms[k]) begin
      if (k > 0) enq_dist(6'd63);
    end
    enq_dist(6'd0); enq_dist(6'd1); enq_dist(6'd2);
    enq_dist(6'd3); enq_dist(6'd5); enq_dist(6'd31);
    enq_dist(6'd32); enq_dist(6'd62);
    drv_en = 1'b1;
    wait_drain();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(bchg_pkg::REG_FIELD_DEGREE, {4'($urandom_range(0, 15)), ms[ph]});
      reg_write(bchg_pkg::REG_PRIM_POLY,
                ph == 6 ? 7'd0 : ps[ph] ^ (ph == 7 ? 7'h40 : 7'h00));
      enq_dist(6'd63); enq_dist(6'd1);
      feed(20, 1'b1);
      wait_drain();
    end
    for (int ph = 0; ph < 16; ph++) begin
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) reg_write(bchg_pkg::REG_FIELD_DEGREE, 7'($urandom_range(0, 127)));
      else reg_write(bchg_pkg::REG_FIELD_DEGREE, 7'($urandom_range(2, 6)));
      if ($urandom_range(0, 1)) reg_write(bchg_pkg::REG_PRIM_POLY, 7'($urandom_range(0, 127)));
      else reg_write(bchg_pkg::REG_PRIM_POLY, ps[$urandom_range(0, 4)]);
      feed(12, 1'b0);
      feed(12, 1'b1);
      wait_drain();
    end
    repeat (1000) @(posedge clk);
    $display("Ran %0d distances, %0d results back: %0d primitive and %0d non-primitive.",
             sent, got, prim_seen, nonprim_seen);
    $display("Covered field degrees 0 to 7 and malformed reduction polynomials.");
    if (mismatches == 0 && gen_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
